// ===== design/dhlt_pkg.sv =====
`timescale 1ns / 1ps
package dhlt_pkg;

  localparam int AtanEntries = 24;
  localparam logic signed [35:0] Q30HalfPi    = 36'sd1686629713;
  localparam logic signed [35:0] Q30QuarterPi = 36'sd843314857;
  localparam logic signed [35:0] Q30Gain      = 36'sd652032874;

  typedef enum logic [1:0] {
    KIND_REVOLUTE  = 2'd0,
    KIND_PRISMATIC = 2'd1,
    KIND_FIXED     = 2'd2,
    KIND_SPARE     = 2'd3
  } joint_kind_e;

  localparam logic [2:0] REG_BASE_THETA  = 3'd0;
  localparam logic [2:0] REG_BASE_D      = 3'd1;
  localparam logic [2:0] REG_LINK_A      = 3'd2;
  localparam logic [2:0] REG_TWIST_ALPHA = 3'd3;
  localparam logic [2:0] REG_JOINT_OFS   = 3'd4;
  localparam logic [2:0] REG_JOINT_KIND  = 3'd5;
  localparam logic [2:0] REG_CONVENTION  = 3'd6;

  function automatic logic signed [35:0] atan_q30(input int idx);
    logic signed [35:0] r;
    begin
      case (idx)
        0: r = 36'sd843314856;   1: r = 36'sd497837829;
        2: r = 36'sd263043836;   3: r = 36'sd133525158;
        4: r = 36'sd67021686;    5: r = 36'sd33543515;
        6: r = 36'sd16775850;    7: r = 36'sd8388437;
        8: r = 36'sd4194282;     9: r = 36'sd2097149;
        10: r = 36'sd1048575;    11: r = 36'sd524287;
        12: r = 36'sd262143;     13: r = 36'sd131071;
        14: r = 36'sd65535;      15: r = 36'sd32767;
        16: r = 36'sd16383;      17: r = 36'sd8191;
        18: r = 36'sd4095;       19: r = 36'sd2047;
        20: r = 36'sd1023;       21: r = 36'sd511;
        22: r = 36'sd255;        23: r = 36'sd127;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    begin
      if (v > 34'sh07FFFFFFF) return 32'sh7FFFFFFF;
      else if (v < -34'sh080000000) return 32'sh80000000;
      else return v[31:0];
    end
  endfunction

endpackage

// ===== design/dhlt_sincos.sv =====
`timescale 1ns / 1ps
// Pipelined sine and cosine: three reduction stages, one register per CORDIC step, map stage.
module dhlt_sincos
  import dhlt_pkg::*;
#(
  parameter int FracBits = 16,
  parameter int Iters    = 16
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [31:0]         angle_i,
  output logic signed [FracBits+1:0] sin_o,
  output logic signed [FracBits+1:0] cos_o
);
  localparam int N = (Iters < AtanEntries) ? Iters : AtanEntries;
  localparam int W = 36;
  localparam int KW = 26;
  localparam int RecipShift = 30 + FracBits;
  // 2^60 over pi/2 in Q30: angle * RecipHalfPi >> RecipShift estimates the quadrant count
  localparam logic signed [32:0] RecipHalfPi = 33'sd683565276;
  localparam logic signed [64:0] RecipRound = 65'sd1 <<< (RecipShift - 1);
  localparam logic signed [W-1:0] One = W'(1) <<< FracBits;
  localparam logic signed [W-1:0] Half = W'(1) <<< (29 - FracBits);

  logic signed [W-1:0] t_q;
  logic signed [KW-1:0] kest_q;
  logic signed [W-1:0] r_q;
  logic [1:0] kl_q;
  logic [1:0] quad_q [0:N];
  logic signed [W-1:0] x_q [0:N];
  logic signed [W-1:0] y_q [0:N];
  logic signed [W-1:0] zz_q [0:N];

  // stage 0: scale to Q30 and estimate the nearest quadrant
  logic signed [63:0] t_w;
  logic signed [64:0] prod_w;
  always_comb begin
    t_w = 64'(angle_i) <<< (30 - FracBits);
    prod_w = 65'(angle_i) * 65'(RecipHalfPi) + RecipRound;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= t_w[W-1:0];
      kest_q <= KW'(prod_w >>> RecipShift);
    end
  end

  // stage 1: remainder against the estimate, exact modulo 2^W
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= t_q + Q30QuarterPi - kest_q * Q30HalfPi;
      kl_q <= kest_q[1:0];
    end
  end

  // stage 2: correct the estimate by one step either way, form the residual
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= Q30Gain;
      y_q[0] <= '0;
      if (r_q < 0) begin
        zz_q[0] <= r_q + Q30HalfPi - Q30QuarterPi;
        quad_q[0] <= kl_q - 2'd1;
      end else if (r_q >= Q30HalfPi) begin
        zz_q[0] <= r_q - Q30HalfPi - Q30QuarterPi;
        quad_q[0] <= kl_q + 2'd1;
      end else begin
        zz_q[0] <= r_q - Q30QuarterPi;
        quad_q[0] <= kl_q;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quad_q[i+1] <= quad_q[i];
        if (!zz_q[i][W-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          zz_q[i+1] <= zz_q[i] - atan_q30(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          zz_q[i+1] <= zz_q[i] + atan_q30(i);
        end
      end
    end
  end

  function automatic logic signed [FracBits+1:0] to_frac(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    begin
      r = (v + Half) >>> (30 - FracBits);
      if (r > One) r = One;
      if (r < -One) r = -One;
      return r[FracBits+1:0];
    end
  endfunction

  logic signed [W-1:0] c_w, s_w;
  always_comb begin
    case (quad_q[N])
      2'd0: begin c_w = x_q[N];  s_w = y_q[N];  end
      2'd1: begin c_w = -y_q[N]; s_w = x_q[N];  end
      2'd2: begin c_w = -x_q[N]; s_w = -y_q[N]; end
      default: begin c_w = y_q[N]; s_w = -x_q[N]; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= to_frac(c_w);
      sin_o <= to_frac(s_w);
    end
  end
endmodule

// ===== design/dh_link_transform_unit.sv =====
`timescale 1ns / 1ps
// A joint value passes stage A (joint sums), the sine/cosine pipelines, the product registers and the output registers.
// Throughput: one joint value per cycle while the output is not stalled; the CORDIC pipeline has one stage per step.
// A stall on the output freezes the whole pipeline in place.
// Reset clears valid bits and configuration registers; data registers are not reset.
module dh_link_transform_unit
  import dhlt_pkg::*;
#(
  parameter int FRAC_BITS       = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [31:0]          joint_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [FRAC_BITS+1:0] rot_00_o, rot_01_o, rot_02_o,
  output logic signed [FRAC_BITS+1:0] rot_10_o, rot_11_o, rot_12_o,
  output logic signed [FRAC_BITS+1:0] rot_20_o, rot_21_o, rot_22_o,
  output logic signed [31:0]          pos_x_o,
  output logic signed [31:0]          pos_y_o,
  output logic signed [31:0]          pos_z_o
);
  localparam int N = (TRIG_ITERATIONS < AtanEntries) ? TRIG_ITERATIONS : AtanEntries;
  localparam int TrigLat = N + 4;
  localparam int Depth = TrigLat + 3;
  localparam int RW = FRAC_BITS + 2;

  logic signed [31:0] base_theta_q, base_d_q, link_a_q, alpha_q, ofs_q;
  joint_kind_e kind_q;
  logic conv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_theta_q <= '0; base_d_q <= '0; link_a_q <= '0;
      alpha_q <= '0; ofs_q <= '0; kind_q <= KIND_REVOLUTE; conv_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BASE_THETA:  base_theta_q <= cfg_data_i;
        REG_BASE_D:      base_d_q <= cfg_data_i;
        REG_LINK_A:      link_a_q <= cfg_data_i;
        REG_TWIST_ALPHA: alpha_q <= cfg_data_i;
        REG_JOINT_OFS:   ofs_q <= cfg_data_i;
        REG_JOINT_KIND:  kind_q <= joint_kind_e'(cfg_data_i[1:0]);
        REG_CONVENTION:  conv_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic en;
  logic [Depth-1:0] vld_q;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], in_valid_i};
  end

  // stage A: joint sums
  logic signed [31:0] sum_w, theta_q, d_q [0:TrigLat+1];
  assign sum_w = sat32(34'(ofs_q) + 34'(joint_value_i));
  always_ff @(posedge clk_i) begin
    if (en) begin
      theta_q <= base_theta_q;
      d_q[0] <= base_d_q;
      case (kind_q)
        KIND_REVOLUTE:  theta_q <= sat32(34'(base_theta_q) + 34'(sum_w));
        KIND_PRISMATIC: d_q[0] <= sat32(34'(base_d_q) + 34'(sum_w));
        default:        theta_q <= sat32(34'(base_theta_q) + 34'(ofs_q));
      endcase
    end
  end

  for (genvar i = 0; i < TrigLat + 1; i++) begin : g_dline
    always_ff @(posedge clk_i) if (en) d_q[i+1] <= d_q[i];
  end

  logic signed [RW-1:0] st, ct, sa, ca;
  dhlt_sincos #(.FracBits(FRAC_BITS), .Iters(TRIG_ITERATIONS)) u_theta (
    .clk_i, .en_i(en), .angle_i(theta_q), .sin_o(st), .cos_o(ct));
  dhlt_sincos #(.FracBits(FRAC_BITS), .Iters(TRIG_ITERATIONS)) u_alpha (
    .clk_i, .en_i(en), .angle_i(alpha_q), .sin_o(sa), .cos_o(ca));

  // stage M: products, then rounding and output
  logic signed [63:0] p_q [0:5];
  logic signed [RW-1:0] st_q, ct_q, sa_q, ca_q;
  logic signed [31:0] d_m;
  assign d_m = d_q[TrigLat];
  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= st; ct_q <= ct; sa_q <= sa; ca_q <= ca;
      p_q[0] <= 64'(st) * 64'(ca);
      p_q[1] <= 64'(st) * 64'(sa);
      p_q[2] <= 64'(ct) * 64'(ca);
      p_q[3] <= 64'(ct) * 64'(sa);
      if (!conv_q) begin
        p_q[4] <= 64'(link_a_q) * 64'(ct);
        p_q[5] <= 64'(link_a_q) * 64'(st);
      end else begin
        p_q[4] <= 64'(sa) * 64'(d_m);
        p_q[5] <= 64'(ca) * 64'(d_m);
      end
    end
  end

  function automatic logic signed [31:0] mulq(input logic signed [63:0] p);
    logic signed [63:0] r;
    begin
      r = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r > 64'sh7FFFFFFF) r = 64'sh7FFFFFFF;
      if (r < -64'sh80000000) r = -64'sh80000000;
      return r[31:0];
    end
  endfunction

  logic signed [31:0] m0, m1, m2, m3, m4, m5;
  assign m0 = mulq(p_q[0]); assign m1 = mulq(p_q[1]);
  assign m2 = mulq(p_q[2]); assign m3 = mulq(p_q[3]);
  assign m4 = mulq(p_q[4]); assign m5 = mulq(p_q[5]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rot_00_o <= ct_q;
      rot_22_o <= ca_q;
      if (!conv_q) begin
        rot_01_o <= -m0[RW-1:0]; rot_02_o <= m1[RW-1:0];
        rot_10_o <= st_q;        rot_11_o <= m2[RW-1:0];
        rot_12_o <= -m3[RW-1:0]; rot_20_o <= '0;
        rot_21_o <= sa_q;
        pos_x_o <= m4; pos_y_o <= m5; pos_z_o <= d_q[TrigLat+1];
      end else begin
        rot_01_o <= -st_q;       rot_02_o <= '0;
        rot_10_o <= m0[RW-1:0];  rot_11_o <= m2[RW-1:0];
        rot_12_o <= -sa_q;       rot_20_o <= m1[RW-1:0];
        rot_21_o <= m3[RW-1:0];
        pos_x_o <= link_a_q;
        pos_y_o <= sat32(-34'(m4));
        pos_z_o <= m5;
      end
    end
  end
endmodule

// ===== design/dhlt_checker.sv =====
`timescale 1ns / 1ps
module dhlt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic signed [17:0] rot_00_o,
  input logic signed [31:0] pos_x_o
);
  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)) else $error("stall without back-pressure");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(rot_00_o) && $stable(pos_x_o)))
    else $error("stalled result changed");
  a_no_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o) else $error("input blocked while output empty");
endmodule

bind dh_link_transform_unit dhlt_checker u_dhlt_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .rot_00_o, .pos_x_o);

// ===== dv/dh_link_transform_unit_tb.sv =====
`timescale 1ns / 1ps
module dh_link_transform_unit_tb;
  import dhlt_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int STALL_PERCENT = 19;
  localparam logic [2:0] REG_UNUSED   = 3'd7;
  localparam logic       DH_STANDARD  = 1'b0;
  localparam logic       DH_MODIFIED  = 1'b1;
  localparam longint     ONE_Q16      = 65536;

  typedef struct {
    logic [17:0] rot [9];
    logic [31:0] pos [3];
  } link_frame_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [2:0]        cfg_index_i = '0;
  logic [31:0]       cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic signed [31:0] joint_value_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic signed [17:0] rot_00_o, rot_01_o, rot_02_o, rot_10_o, rot_11_o, rot_12_o;
  logic signed [17:0] rot_20_o, rot_21_o, rot_22_o;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o;

  dh_link_transform_unit dut (.*);

  // shadow configuration
  longint      cur_theta, cur_d, cur_a, cur_alpha, cur_ofs;
  joint_kind_e cur_kind;
  logic        cur_conv;

  link_frame_t expected_frames[$];
  int          mismatches = 0;
  int          frames_seen = 0;
  int          items_sent = 0;
  int          cycles = 0;
  bit          send_idle_on = 1'b1;
  bit          recv_idle_on = 1'b1;
  int          hold_left = 0;

  longint atan_tab [16] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                            33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                            524287, 262143, 131071, 65535, 32767};

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frames pending", cycles,
               expected_frames.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint q30_to_q16(longint v);
    longint r;
    r = (v + (64'sd1 << 13)) >>> 14;
    if (r > ONE_Q16) r = ONE_Q16;
    if (r < -ONE_Q16) r = -ONE_Q16;
    return r;
  endfunction

  function automatic longint fix_mul(longint a, longint b);
    return clamp32((a * b + (64'sd1 << 15)) >>> 16);
  endfunction

  // quadrant reduction, then CORDIC rotation on the residual
  task automatic angle_sin_cos(input longint ang, output longint s, output longint c);
    longint t, u, k, z, x, y, nx, hp;
    logic [1:0] quad;
    hp = longint'(Q30HalfPi);
    t = ang * 16384;
    u = t + longint'(Q30QuarterPi);
    k = u / hp;
    if ((u % hp) != 0 && u < 0) k--;
    z = t - k * hp;
    x = longint'(Q30Gain);
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_tab[i];
      end
      x = nx;
    end
    quad = k[1:0];
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = q30_to_q16(c);
    s = q30_to_q16(s);
  endtask

  task automatic predict_link_frame(input longint q, output link_frame_t f);
    longint theta, d, st, ct, sa, ca;
    longint r [12];
    theta = cur_theta;
    d = cur_d;
    if (cur_kind == KIND_REVOLUTE) theta = clamp32(theta + clamp32(cur_ofs + q));
    else if (cur_kind == KIND_PRISMATIC) d = clamp32(d + clamp32(cur_ofs + q));
    else theta = clamp32(theta + cur_ofs);
    angle_sin_cos(theta, st, ct);
    angle_sin_cos(cur_alpha, sa, ca);
    if (cur_conv == DH_STANDARD) begin
      r[0] = ct; r[1] = -fix_mul(st, ca); r[2] = fix_mul(st, sa);
      r[3] = st; r[4] = fix_mul(ct, ca);  r[5] = -fix_mul(ct, sa);
      r[6] = 0;  r[7] = sa;               r[8] = ca;
      r[9] = fix_mul(cur_a, ct);
      r[10] = fix_mul(cur_a, st);
      r[11] = d;
    end else begin
      r[0] = ct;              r[1] = -st;             r[2] = 0;
      r[3] = fix_mul(st, ca); r[4] = fix_mul(ct, ca); r[5] = -sa;
      r[6] = fix_mul(st, sa); r[7] = fix_mul(ct, sa); r[8] = ca;
      r[9] = cur_a;
      r[10] = clamp32(-fix_mul(sa, d));
      r[11] = fix_mul(ca, d);
    end
    for (int j = 0; j < 9; j++) f.rot[j] = r[j][17:0];
    for (int j = 0; j < 3; j++) f.pos[j] = r[9 + j][31:0];
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
  endtask

  // receiver: long hold when requested, otherwise random stalls while recv_idle_on is set
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall_i <= recv_idle_on && ($urandom_range(99) < STALL_PERCENT);
    end
  end

  always @(posedge clk_i) begin
    link_frame_t want;
    logic [17:0] rot_got [9];
    logic [31:0] pos_got [3];
    if (rst_ni && out_valid_o && !out_stall_i) begin
      frames_seen++;
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected transfer", 0, 0);
      end else begin
        want = expected_frames.pop_front();
        rot_got = '{rot_00_o, rot_01_o, rot_02_o, rot_10_o, rot_11_o, rot_12_o,
                    rot_20_o, rot_21_o, rot_22_o};
        pos_got = '{pos_x_o, pos_y_o, pos_z_o};
        for (int j = 0; j < 9; j++)
          if (rot_got[j] !== want.rot[j])
            report_mismatch($sformatf("rot_%0d%0d", j / 3, j % 3), rot_got[j], want.rot[j]);
        for (int j = 0; j < 3; j++)
          if (pos_got[j] !== want.pos[j])
            report_mismatch($sformatf("pos_%0d", j), pos_got[j], want.pos[j]);
      end
    end
  end

  task automatic send_joint(input logic signed [31:0] q);
    link_frame_t f;
    @(negedge clk_i);
    while (send_idle_on && ($urandom_range(99) < STALL_PERCENT)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    joint_value_i <= q;
    do @(posedge clk_i); while (in_stall_o);
    predict_link_frame(longint'(q), f);
    expected_frames.push_back(f);
    items_sent++;
  endtask

  // hold the input until every frame is back and the pipeline is empty
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (expected_frames.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_BASE_THETA:  cur_theta = longint'(signed'(val));
      REG_BASE_D:      cur_d = longint'(signed'(val));
      REG_LINK_A:      cur_a = longint'(signed'(val));
      REG_TWIST_ALPHA: cur_alpha = longint'(signed'(val));
      REG_JOINT_OFS:   cur_ofs = longint'(signed'(val));
      REG_JOINT_KIND:  cur_kind = joint_kind_e'(val[1:0]);
      REG_CONVENTION:  cur_conv = val[0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] th, input logic [31:0] d, input logic [31:0] a,
                           input logic [31:0] al, input logic [31:0] ofs,
                           input joint_kind_e kind, input logic conv);
    write_reg(REG_BASE_THETA, th);
    write_reg(REG_BASE_D, d);
    write_reg(REG_LINK_A, a);
    write_reg(REG_TWIST_ALPHA, al);
    write_reg(REG_JOINT_OFS, ofs);
    write_reg(REG_JOINT_KIND, {30'd0, kind});
    write_reg(REG_CONVENTION, {31'd0, conv});
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'd0;
      3, 4: return $urandom_range(917504) - 458752;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_joint(32'sd0);
    send_joint(32'sh7FFFFFFF);
    send_joint(32'sh80000000);
    send_joint(32'sd1);
    send_joint(-32'sd1);
    wait_drained();
  endtask

  task automatic test_directed_extremes();
    // saturate theta and scale a full-range link length
    write_all(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h00019220, 32'h7FFFFFFF,
              KIND_REVOLUTE, DH_STANDARD);
    send_joint(32'sh7FFFFFFF);
    send_joint(32'sh80000000);
    send_joint(32'sd102944);
    wait_drained();
    write_all(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
              KIND_PRISMATIC, DH_MODIFIED);
    send_joint(32'sh80000000);
    send_joint(32'sh7FFFFFFF);
    send_joint(32'sd0);
    wait_drained();
    write_reg(REG_JOINT_KIND, {30'd0, KIND_FIXED});
    write_reg(REG_TWIST_ALPHA, 32'h7FFFFFFF);
    send_joint(32'sh12345678);
    send_joint(-32'sd205887);
    wait_drained();
    // spare kind behaves as fixed; an unused index must change nothing
    write_reg(REG_JOINT_KIND, {30'd0, KIND_SPARE});
    write_reg(REG_UNUSED, 32'hFFFFFFFF);
    write_reg(REG_CONVENTION, {31'd0, DH_STANDARD});
    send_joint(32'sh7FFFFFFF);
    send_joint(32'sd0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    write_all(32'd0, 32'h00030000, 32'h00020000, 32'h0000C90F, 32'd0,
              KIND_REVOLUTE, DH_MODIFIED);
    @(posedge clk_i);
    hold_left = 300;
    for (int i = 0; i < 60; i++) send_joint($urandom);
    wait_drained();
  endtask

  task automatic test_random_phases();
    int n;
    for (int p = 0; p < 9; p++) begin
      write_all(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                joint_kind_e'($urandom_range(3)), 1'($urandom_range(1)));
      send_idle_on = (p != 4);
      recv_idle_on = (p != 4);
      n = 130 + $urandom_range(20);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(1)) send_joint($urandom);
        else if ($urandom_range(3) == 0) send_joint(pick_word());
        else send_joint($urandom_range(917504) - 458752);
      end
      wait_drained();
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  initial begin
    cur_theta = 0; cur_d = 0; cur_a = 0; cur_alpha = 0; cur_ofs = 0;
    cur_kind = KIND_REVOLUTE;
    cur_conv = DH_STANDARD;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_directed_extremes();
    test_backpressure();
    test_random_phases();
    wait_drained();
    $display("sent %0d joint values, checked %0d link frames", items_sent, frames_seen);
    $display("covered all joint kinds, both conventions, saturation and long output holds");
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
